// File: design/zrt_pkg.sv
// Shared constants and types for the zigzag rail transposer.
package zrt_pkg;

	// Buffer depth and the widths that follow from it.
	localparam int MAX_LEN = 64;
	localparam int ADDR_W  = 6;
	localparam int CNT_W   = 7;
	localparam int POS_W   = 8;
	localparam int ROW_W   = 6;
	localparam int RAILS_W = 7;

	// Rail count after reset.
	localparam logic [RAILS_W-1:0] RAILS_RESET = 7'd3;

	// Buffer fill level at which further bytes are dropped.
	localparam logic [CNT_W-1:0] FULL_COUNT = 7'd64;

	// Position walk state of the read sequencer.
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [ROW_W-1:0] row;
		logic             alt;
	} walk_t;

	// Block geometry fixed for the length of one emission.
	typedef struct packed {
		logic [CNT_W-1:0]   len;
		logic [RAILS_W-1:0] rails;
		logic [POS_W-1:0]   cycle;
	} geom_t;

endpackage

// File: design/zrt_buf.sv
// Byte buffer of the transposer: one write port, one registered read port.
module zrt_buf (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [zrt_pkg::ADDR_W-1:0] wr_addr,
	input  logic [7:0]                wr_data,
	input  logic [zrt_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0]                rd_data
);
	import zrt_pkg::*;

	logic [7:0] mem_q [MAX_LEN];
	logic [7:0] rd_data_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/zrt_step.sv
// Step unit: adds a step and compares with the block length to give the next buffer position in rail order.
module zrt_step (
	input  zrt_pkg::walk_t cur,
	input  zrt_pkg::geom_t geom,
	output zrt_pkg::walk_t nxt
);
	import zrt_pkg::*;

	logic             edge_row;
	logic [POS_W-1:0] twice_row;
	logic [POS_W-1:0] step;
	logic [POS_W-1:0] sum;

	// With one rail the step is 1; otherwise the first and last rows step by a full cycle and middle rows alternate.
	always_comb begin
		edge_row  = (cur.row == '0) || ({1'b0, cur.row} == geom.rails - 7'd1);
		twice_row = {1'b0, cur.row, 1'b0};
		if (geom.rails == 7'd1) begin
			step = 8'd1;
		end else if (edge_row) begin
			step = geom.cycle;
		end else if (cur.alt) begin
			step = twice_row;
		end else begin
			step = geom.cycle - twice_row;
		end
		sum = cur.pos + step;
	end

	// Stay on the row while the position is inside the block, else start the next row.
	always_comb begin
		if (sum < {1'b0, geom.len}) begin
			nxt.pos = sum;
			nxt.row = cur.row;
			nxt.alt = ~cur.alt;
		end else begin
			nxt.row = cur.row + 6'd1;
			nxt.pos = {2'b00, cur.row + 6'd1};
			nxt.alt = 1'b0;
		end
	end

endmodule

// File: design/zigzag_rail_transposer_unit.sv
// Top level of the zigzag rail transposer: load sequencer, read walk and output stage.
//
// Bytes of a block enter on the in channel (in_valid/in_ready), one per
// transaction, with in_last on the final byte. Each byte is written into a
// 64-entry buffer; bytes beyond 64 are dropped and the overflow is
// reported on the last result of the block.
// After the last byte the block leaves on the out channel in rail order, one
// transaction per stored byte, out_last on the final one and overflowed on
// that same result. Each result is read from the buffer in ST_READ and then
// offered in ST_SHOW, where it is held until it is taken; only then does the
// read of the next result begin. After the last byte is accepted the
// sequencer passes through ST_READ before it offers the first result. While
// a block is emitted, in_ready is low.
// A stalled receiver simply holds the current result in place; nothing is
// lost. num_rails is to be written through num_rails_wr only while the block
// is idle; the block itself does not enforce this. Reset clears the fill
// level and the overflow flag and sets three rails; the buffer contents are not cleared.
module zigzag_rail_transposer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       num_rails_wr,
	input  logic [6:0] num_rails,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       overflowed
);
	import zrt_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_SHOW
	} state_t;

	state_t             state_q;
	logic [RAILS_W-1:0] num_rails_q;
	logic [CNT_W-1:0]   fill_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   cnt_q;
	walk_t              walk_q;
	geom_t              geom_q;
	walk_t              walk_nxt;

	logic               in_xact;
	logic               out_xact;
	logic               full;
	logic               final_res;
	logic [CNT_W-1:0]   len_c;
	logic [RAILS_W-1:0] rails_c;
	logic [7:0]         rd_data;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_SHOW);
	assign in_xact   = in_valid && in_ready;
	assign out_xact  = out_valid && out_ready;
	assign full      = (fill_q == FULL_COUNT);
	assign final_res = (cnt_q == geom_q.len - 7'd1);

	// Block length, saturated at the buffer depth, and rail count clamped to the range 1..length.
	always_comb begin
		len_c   = full ? fill_q : fill_q + 7'd1;
		rails_c = (num_rails_q == '0) ? 7'd1 : num_rails_q;
		if (rails_c > len_c) begin
			rails_c = len_c;
		end
	end

	zrt_buf u_buf (
		.clk     (clk),
		.wr_en   (in_xact && !full),
		.wr_addr (fill_q[ADDR_W-1:0]),
		.wr_data (in_byte),
		.rd_addr (walk_q.pos[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	zrt_step u_step (
		.cur  (walk_q),
		.geom (geom_q),
		.nxt  (walk_nxt)
	);

	// The result byte comes straight from the buffer read register.
	assign out_byte   = rd_data;
	assign out_last   = out_valid && final_res;
	assign overflowed = out_valid && final_res && ovf_q;

	// Sequencer: load bytes, then read and offer one result at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			num_rails_q <= RAILS_RESET;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			walk_q      <= '0;
			geom_q      <= '0;
		end else begin
			if (num_rails_wr) begin
				num_rails_q <= num_rails;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_xact) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							fill_q <= fill_q + 7'd1;
						end
						if (in_last) begin
							geom_q.len   <= len_c;
							geom_q.rails <= rails_c;
							geom_q.cycle <= {rails_c - 7'd1, 1'b0};
							walk_q       <= '0;
							cnt_q        <= '0;
							state_q      <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (out_xact) begin
						if (final_res) begin
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							walk_q  <= walk_nxt;
							cnt_q   <= cnt_q + 7'd1;
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// File: verif/tb_zigzag_rail_transposer_unit.sv
// Self-checking testbench for the zigzag rail transposer with a rail order predictor.

module tb_zigzag_rail_transposer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// One emitted byte as the out channel presents it.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ovf;
	} rail_byte_t;

	// Predicts the rail order of every block and checks the emitted bytes in order.
	class rail_order_board;
		logic [7:0]             block_bytes [zrt_pkg::MAX_LEN];
		int unsigned            stored;
		bit                     dropped;
		logic [zrt_pkg::RAILS_W-1:0] rails_cfg;
		rail_byte_t             rail_order_q [$];
		int unsigned            errors;

		function new();
			stored    = 0;
			dropped   = 1'b0;
			rails_cfg = zrt_pkg::RAILS_RESET;
			errors    = 0;
		endfunction

		function void set_rails(logic [zrt_pkg::RAILS_W-1:0] value);
			rails_cfg = value;
		endfunction

		function int unsigned pending();
			return rail_order_q.size();
		endfunction

		// Store one accepted byte; on the last byte, queue the block in rail order.
		function void note_input(logic [7:0] data, logic last);
			int unsigned rows;
			int unsigned period;
			int unsigned pos;
			int unsigned first_idx;
			bit          alt;
			rail_byte_t  item;

			if (stored < zrt_pkg::MAX_LEN) begin
				block_bytes[stored] = data;
				stored++;
			end else begin
				dropped = 1'b1;
			end
			if (!last)
				return;

			// Zero rails act as one; more rails than bytes act as the byte count.
			rows = rails_cfg;
			if (rows < 1)
				rows = 1;
			if (rows > stored)
				rows = stored;

			first_idx = rail_order_q.size();
			item.last = 1'b0;
			item.ovf  = 1'b0;
			if (rows == 1) begin
				for (int k = 0; k < stored; k++) begin
					item.data = block_bytes[k];
					rail_order_q.push_back(item);
				end
			end else begin
				period = 2 * (rows - 1);
				for (int unsigned r = 0; r < rows; r++) begin
					pos = r;
					alt = 1'b0;
					while (pos < stored) begin
						item.data = block_bytes[pos];
						rail_order_q.push_back(item);
						if (r == 0 || r == rows - 1)
							pos += period;
						else
							pos += alt ? 2 * r : period - 2 * r;
						alt = !alt;
					end
				end
			end

			// The final byte of the block carries the last mark and the overflow report.
			if (rail_order_q.size() > first_idx) begin
				item      = rail_order_q.pop_back();
				item.last = 1'b1;
				item.ovf  = dropped;
				rail_order_q.push_back(item);
			end
			stored  = 0;
			dropped = 1'b0;
		endfunction

		// Compare one accepted output transaction with the oldest prediction.
		function void check_result(logic [7:0] data, logic last, logic ovf);
			rail_byte_t want;

			if (rail_order_q.size() == 0) begin
				$display("%0t: unexpected output byte %02h last %0b overflowed %0b",
					$time, data, last, ovf);
				errors++;
				return;
			end
			want = rail_order_q.pop_front();
			if (want.data !== data) begin
				$display("%0t: out_byte expected %02h, actual %02h", $time, want.data, data);
				errors++;
			end
			if (want.last !== last) begin
				$display("%0t: out_last expected %0b, actual %0b", $time, want.last, last);
				errors++;
			end
			if (want.ovf !== ovf) begin
				$display("%0t: overflowed expected %0b, actual %0b", $time, want.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       num_rails_wr;
	logic [6:0] num_rails;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       overflowed;

	int send_gap_pct;
	int recv_stall_pct;

	rail_order_board board;

	zigzag_rail_transposer_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.num_rails_wr (num_rails_wr),
		.num_rails    (num_rails),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.overflowed   (overflowed)
	);

	// 10 ns clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random at the configured rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Watch both channels; a transaction happens when valid and ready are high at an edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid === 1'b1 && in_ready === 1'b1)
				board.note_input(in_byte, in_last);
			if (out_valid === 1'b1 && out_ready === 1'b1)
				board.check_result(out_byte, out_last, overflowed);
		end
	end

	// Offer one byte after an optional random gap and hold it until it is taken.
	task automatic send_byte(input logic [7:0] data, input logic last);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= data;
		in_last  <= last;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
	endtask

	// Random block of the given length, last byte flagged.
	task automatic send_block(input int unsigned len);
		for (int unsigned k = 0; k < len; k++)
			send_byte(8'($urandom_range(0, 255)), k == len - 1);
	endtask

	// Let the block drain completely so the rail register can change safely.
	// It first waits on the clock, so that the monitor has noted the last accepted byte.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_rails(input logic [6:0] value);
		num_rails_wr <= 1'b1;
		num_rails    <= value;
		board.set_rails(value);
		@(posedge clk);
		num_rails_wr <= 1'b0;
	endtask

	// Main stimulus: directed blocks, then random blocks over several rail settings.
	initial begin
		logic [6:0]  rail_settings [10];
		int unsigned sent;
		int unsigned len;

		board          = new();
		arst_n         = 1'b0;
		num_rails_wr   = 1'b0;
		num_rails      = 7'd0;
		in_valid       = 1'b0;
		in_byte        = 8'd0;
		in_last        = 1'b0;
		out_ready      = 1'b0;
		send_gap_pct   = 25;
		recv_stall_pct = 46;
		rail_settings  = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd4, 7'd65, 7'd63, 7'd5, 7'd0};
		rail_settings[9] = 7'($urandom_range(1, 64));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed blocks at the reset rail count: single byte, byte extremes, short zigzags.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hFF, 1'b1);
		for (int k = 0; k < 5; k++)
			send_byte(8'(8'h10 + k), k == 4);
		for (int k = 0; k < 8; k++)
			send_byte(8'(8'hF0 + k), k == 7);
		wait_drained();

		// Random phases, one per rail setting; idling pattern changes over the run.
		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 4) begin
				send_gap_pct   = 25;
				recv_stall_pct = 46;
			end else if (ph < 7) begin
				send_gap_pct   = 46;
				recv_stall_pct = 25;
			end else begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			write_rails(rail_settings[ph]);
			sent = 0;
			// Some phases open with a block near or past the buffer depth.
			if (ph % 3 == 2 || ph == 3) begin
				len = $urandom_range(63, 70);
				send_block(len);
				sent += len;
			end
			while (sent < 16) begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(13, 40);
				else
					len = $urandom_range(1, 12);
				send_block(len);
				sent += len;
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		// Every predicted byte must have come out.
		if (board.pending() != 0) begin
			$display("%0t: outstanding results expected 0, actual %0d", $time, board.pending());
			board.errors++;
		end
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Run limit well beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
design/zrt_pkg.sv
design/zrt_buf.sv
design/zrt_step.sv
design/zigzag_rail_transposer_unit.sv
verif/tb_zigzag_rail_transposer_unit.sv
